>>> rtl/vnwf_pkg.sv
// Shared constants, types and helper functions of the value-noise wind field.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package vnwf_pkg;

    // Fixed-point format and field widths.
    localparam int FRAC_BITS   = 16;
    localparam int ONE_Q       = 1 << FRAC_BITS;
    localparam int MAX_OCTAVES = 8;
    localparam int CELL_W      = 10;
    localparam int COORD_W     = 27;
    localparam int CINT_W      = COORD_W - FRAC_BITS;
    localparam int INV_W       = 24;
    localparam int OCT_W       = 4;
    localparam int PERS_W      = 18;
    localparam int GAIN_W      = 17;
    localparam int ANG_W       = 19;
    localparam int SMOOTH_W    = 17;
    localparam int NOISE_W     = 21;
    localparam int AMP_W       = 31;
    localparam int SUM_W       = 56;
    localparam int OUT_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Hash multipliers, pi and the Y-component offsets, all Q.16 where fractional.
    localparam logic [31:0]        HASH_C1 = 32'd3284157443;
    localparam logic [31:0]        HASH_C2 = 32'd1911520717;
    localparam logic [31:0]        HASH_C3 = 32'd2048419325;
    localparam logic [17:0]        PI_Q    = 18'd205887;
    localparam logic [COORD_W-1:0] OFS_X_Q = COORD_W'(2058486);
    localparam logic [COORD_W-1:0] OFS_Y_Q = COORD_W'(1781268);
    localparam logic [AMP_W-1:0]   AMP_MAX = AMP_W'(1 << 30);

    // Register reset values.
    localparam logic [INV_W-1:0]  RST_INV_SCALE   = INV_W'(4096);
    localparam logic [OCT_W-1:0]  RST_OCTAVES     = OCT_W'(4);
    localparam logic [PERS_W-1:0] RST_PERSISTENCE = PERS_W'(32768);
    localparam logic [GAIN_W-1:0] RST_NORM_GAIN   = GAIN_W'(34953);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_SCALE   = 2'd0,
        REG_OCTAVES     = 2'd1,
        REG_PERSISTENCE = 2'd2,
        REG_NORM_GAIN   = 2'd3
    } t_cfg_reg;

    typedef logic [COORD_W-1:0]        t_coord;
    typedef logic signed [NOISE_W-1:0] t_noise;

    function automatic logic [31:0] rot16(input logic [31:0] v);
        return {v[15:0], v[31:16]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/vnwf_if.sv
// Handshake channels of the value-noise wind field: cell input, wind output
// and configuration writes. Widths come from vnwf_pkg.
`default_nettype none

interface vnwf_cell_if;
    logic                          valid;
    logic                          ready;
    logic [vnwf_pkg::CELL_W-1:0]   cell_x;
    logic [vnwf_pkg::CELL_W-1:0]   cell_y;
    modport source (output valid, cell_x, cell_y, input ready);
    modport sink   (input valid, cell_x, cell_y, output ready);
endinterface

interface vnwf_wind_if;
    logic                               valid;
    logic                               ready;
    logic signed [vnwf_pkg::OUT_W-1:0]  wind_x;
    logic signed [vnwf_pkg::OUT_W-1:0]  wind_y;
    modport source (output valid, wind_x, wind_y, input ready);
    modport sink   (input valid, wind_x, wind_y, output ready);
endinterface

interface vnwf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vnwf_pkg::CFG_IDX_W-1:0]      index;
    logic [vnwf_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/vnwf_noise.sv
// Eight-stage pipelined hashed-lattice value noise for one Q.16 point.
// Depends on vnwf_pkg for widths, hash constants and rot16.
`default_nettype none

module vnwf_noise (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [vnwf_pkg::INV_W-1:0]      i_inv,
    input  wire vnwf_pkg::t_coord                i_qx,
    input  wire vnwf_pkg::t_coord                i_qy,
    output vnwf_pkg::t_noise                     o_n
);

    localparam int IW = vnwf_pkg::INV_W;
    localparam int FB = vnwf_pkg::FRAC_BITS;
    localparam int AW = vnwf_pkg::ANG_W;
    localparam int UW = vnwf_pkg::SMOOTH_W;

    // Corner order: 0 = (ix, iy), 1 = (ix, iy+1), 2 = (ix+1, iy), 3 = (ix+1, iy+1).

    // Stage 1: integer and fraction parts times inv_scale.
    logic [vnwf_pkg::CINT_W+IW-1:0] r_mhx, r_mhy;
    logic [FB+IW-1:0]               r_mlx, r_mly;
    // Stage 2: lattice index and fraction.
    logic [31:0]    r_ix, r_iy2;
    logic [FB-1:0]  r_tx, r_ty;
    // Stage 3: first hash multiply and t squared.
    logic [31:0]    r_a0, r_iy3;
    logic [FB-1:0]  r_tx3, r_ty3, r_t2x, r_t2y;
    // Stage 4: second hash multiply and smoothstep.
    logic [31:0]    r_a4 [2];
    logic [31:0]    r_b  [4];
    logic [UW-1:0]  r_ux4, r_uy4;
    // Stage 5: third hash multiply.
    logic [31:0]    r_h  [4];
    logic [UW-1:0]  r_ux5, r_uy5;
    // Stage 6: angle.
    logic [AW-1:0]  r_ang [4];
    logic [UW-1:0]  r_ux6, r_uy6;
    // Stage 7: horizontal blends.
    logic [AW-1:0]  r_top, r_bot;
    logic [UW-1:0]  r_uy7;
    // Stage 8: vertical blend and mapping to [-1, ...).
    vnwf_pkg::t_noise r_n;

    logic [FB+IW-1:0] n_mhx, n_mhy, n_mlx, n_mly;
    logic [31:0]      n_a1;
    logic [17:0]      n_kx, n_ky;
    logic [33:0]      n_px, n_py;
    logic [31:0]      n_b [4];
    logic [31:0]      n_h [4];
    logic [49:0]      n_p [4];
    logic [31:0]      n_t2x, n_t2y;
    logic signed [AW:0]   n_d0, n_d1, n_d2;
    logic signed [AW+UW+1:0] n_m0, n_m1, n_m2;
    logic signed [AW:0]   n_top, n_bot, n_val;

    always_comb begin
        n_mhx = (FB+IW)'(i_qx[vnwf_pkg::COORD_W-1:FB]) * (FB+IW)'(i_inv);
        n_mhy = (FB+IW)'(i_qy[vnwf_pkg::COORD_W-1:FB]) * (FB+IW)'(i_inv);
        n_mlx = (FB+IW)'(i_qx[FB-1:0]) * (FB+IW)'(i_inv);
        n_mly = (FB+IW)'(i_qy[FB-1:0]) * (FB+IW)'(i_inv);

        n_t2x = 32'(r_tx) * 32'(r_tx);
        n_t2y = 32'(r_ty) * 32'(r_ty);

        // Smoothstep: t2 * (3 - 2t), both in Q.16.
        n_kx = 18'(3 * vnwf_pkg::ONE_Q) - {1'b0, r_tx3, 1'b0};
        n_ky = 18'(3 * vnwf_pkg::ONE_Q) - {1'b0, r_ty3, 1'b0};
        n_px = 34'(r_t2x) * 34'(n_kx);
        n_py = 34'(r_t2y) * 34'(n_ky);

        n_a1 = r_a0 + vnwf_pkg::HASH_C1;
        n_b[0] = (r_iy3 ^ vnwf_pkg::rot16(r_a0)) * vnwf_pkg::HASH_C2;
        n_b[1] = ((r_iy3 + 32'd1) ^ vnwf_pkg::rot16(r_a0)) * vnwf_pkg::HASH_C2;
        n_b[2] = (r_iy3 ^ vnwf_pkg::rot16(n_a1)) * vnwf_pkg::HASH_C2;
        n_b[3] = ((r_iy3 + 32'd1) ^ vnwf_pkg::rot16(n_a1)) * vnwf_pkg::HASH_C2;

        for (int c = 0; c < 4; c++) begin
            n_h[c] = (r_a4[c/2] ^ vnwf_pkg::rot16(r_b[c])) * vnwf_pkg::HASH_C3;
            n_p[c] = 50'(r_h[c]) * 50'(vnwf_pkg::PI_Q);
        end

        // lerp(p, q, u) = p + floor((q - p) * u / 2^16).
        n_d0 = $signed({1'b0, r_ang[2]}) - $signed({1'b0, r_ang[0]});
        n_d1 = $signed({1'b0, r_ang[3]}) - $signed({1'b0, r_ang[1]});
        n_m0 = (AW+UW+2)'(n_d0) * (AW+UW+2)'($signed({1'b0, r_ux6}));
        n_m1 = (AW+UW+2)'(n_d1) * (AW+UW+2)'($signed({1'b0, r_ux6}));
        n_top = $signed({1'b0, r_ang[0]}) + (AW+1)'(n_m0 >>> FB);
        n_bot = $signed({1'b0, r_ang[1]}) + (AW+1)'(n_m1 >>> FB);

        n_d2 = $signed({1'b0, r_bot}) - $signed({1'b0, r_top});
        n_m2 = (AW+UW+2)'(n_d2) * (AW+UW+2)'($signed({1'b0, r_uy7}));
        n_val = $signed({1'b0, r_top}) + (AW+1)'(n_m2 >>> FB);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mhx <= n_mhx[vnwf_pkg::CINT_W+IW-1:0];
            r_mhy <= n_mhy[vnwf_pkg::CINT_W+IW-1:0];
            r_mlx <= n_mlx;
            r_mly <= n_mly;

            r_ix  <= r_mhx[31:0] + 32'(r_mlx[FB+IW-1:32]);
            r_iy2 <= r_mhy[31:0] + 32'(r_mly[FB+IW-1:32]);
            r_tx  <= r_mlx[31:FB];
            r_ty  <= r_mly[31:FB];

            r_a0  <= r_ix * vnwf_pkg::HASH_C1;
            r_iy3 <= r_iy2;
            r_tx3 <= r_tx;
            r_ty3 <= r_ty;
            r_t2x <= n_t2x[31:FB];
            r_t2y <= n_t2y[31:FB];

            r_a4[0] <= r_a0;
            r_a4[1] <= n_a1;
            for (int c = 0; c < 4; c++) r_b[c] <= n_b[c];
            r_ux4 <= n_px[FB+UW-1:FB];
            r_uy4 <= n_py[FB+UW-1:FB];

            for (int c = 0; c < 4; c++) r_h[c] <= n_h[c];
            r_ux5 <= r_ux4;
            r_uy5 <= r_uy4;

            for (int c = 0; c < 4; c++) r_ang[c] <= n_p[c][31+AW-1:31];
            r_ux6 <= r_ux5;
            r_uy6 <= r_uy5;

            r_top <= n_top[AW-1:0];
            r_bot <= n_bot[AW-1:0];
            r_uy7 <= r_uy6;

            r_n <= $signed({1'b0, n_val[AW-1:0], 1'b0}) - vnwf_pkg::NOISE_W'(vnwf_pkg::ONE_Q);
        end
    end

    assign o_n = r_n;

endmodule

`default_nettype wire

>>> rtl/value_noise_wind_field.sv
// Value-noise wind field top level; uses vnwf_pkg, the vnwf_*_if channels and vnwf_noise.
// Each accepted cell beat yields one wind beat, in input order, on the stage-14 output register.
// Throughput: one cell per cycle; the whole 14-stage pipeline holds while the output is stalled.
// Reset (synchronous, active low) clears the stage valid bits and loads the register defaults.
// After a persistence write the per-octave amplitude chain, a register per link, settles
// before the first following cell reaches the weighting stage.
`default_nettype none

module value_noise_wind_field (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    vnwf_cell_if.sink      i_cell,
    vnwf_cfg_if.sink       i_cfg,
    vnwf_wind_if.source    o_wind
);

    localparam int NO    = vnwf_pkg::MAX_OCTAVES;
    localparam int FB    = vnwf_pkg::FRAC_BITS;
    localparam int SW    = vnwf_pkg::SUM_W;
    localparam int LAST  = 14;
    localparam int WGT_W = vnwf_pkg::NOISE_W + vnwf_pkg::AMP_W + 1;
    localparam int SH_W  = SW - FB;
    localparam int GP_W  = SH_W + vnwf_pkg::GAIN_W + 1;

    // Configuration registers. The user keeps them stable while cells are in flight; the block
    // does not enforce this, and every stage reads them directly.
    logic [vnwf_pkg::INV_W-1:0]  r_inv_scale;
    logic [vnwf_pkg::OCT_W-1:0]  r_octaves;
    logic [vnwf_pkg::PERS_W-1:0] r_persistence;
    logic [vnwf_pkg::GAIN_W-1:0] r_norm_gain;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale   <= vnwf_pkg::RST_INV_SCALE;
            r_octaves     <= vnwf_pkg::RST_OCTAVES;
            r_persistence <= vnwf_pkg::RST_PERSISTENCE;
            r_norm_gain   <= vnwf_pkg::RST_NORM_GAIN;
        end else if (i_cfg.valid) begin
            case (vnwf_pkg::t_cfg_reg'(i_cfg.index))
                vnwf_pkg::REG_INV_SCALE:   r_inv_scale   <= i_cfg.data[vnwf_pkg::INV_W-1:0];
                vnwf_pkg::REG_OCTAVES:     r_octaves     <= i_cfg.data[vnwf_pkg::OCT_W-1:0];
                vnwf_pkg::REG_PERSISTENCE: r_persistence <= i_cfg.data[vnwf_pkg::PERS_W-1:0];
                vnwf_pkg::REG_NORM_GAIN:   r_norm_gain   <= i_cfg.data[vnwf_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Octave enable: octave o contributes when o is below the count, which saturates
    // at the maximum. A count of zero leaves both sums at zero.
    logic [NO-1:0] oct_en;
    always_comb begin
        for (int o = 0; o < NO; o++) begin
            oct_en[o] = (32'(r_octaves) > o);
        end
    end

    // Amplitude of each octave: persistence^o in Q.16, saturated at 2^30. Octave 0 is one.
    // Each link is its own register, so the chain settles one link after another following a write.
    logic [vnwf_pkg::AMP_W-1:0] amp [NO];
    logic [vnwf_pkg::AMP_W-1:0] r_amp [1:NO-1];
    assign amp[0] = vnwf_pkg::AMP_W'(vnwf_pkg::ONE_Q);

    for (genvar k = 1; k < NO; k++) begin : g_amp
        logic [vnwf_pkg::AMP_W+vnwf_pkg::PERS_W-1:0] n_prod;
        logic [vnwf_pkg::AMP_W+vnwf_pkg::PERS_W-FB-1:0] n_shift;
        assign n_prod  = (vnwf_pkg::AMP_W+vnwf_pkg::PERS_W)'(amp[k-1])
                       * (vnwf_pkg::AMP_W+vnwf_pkg::PERS_W)'(r_persistence);
        assign n_shift = n_prod[vnwf_pkg::AMP_W+vnwf_pkg::PERS_W-1:FB];
        always_ff @(posedge i_clk) begin
            if (n_shift > (vnwf_pkg::AMP_W+vnwf_pkg::PERS_W-FB)'(vnwf_pkg::AMP_MAX)) begin
                r_amp[k] <= vnwf_pkg::AMP_MAX;
            end else begin
                r_amp[k] <= n_shift[vnwf_pkg::AMP_W-1:0];
            end
        end
        assign amp[k] = r_amp[k];
    end

    // Pipeline control. Every stage moves together; when the output register holds a
    // beat that is not taken, the whole pipeline waits and nothing is dropped.
    logic            adv;
    logic [LAST:1]   r_vld;

    assign adv          = !r_vld[LAST] || o_wind.ready;
    assign i_cell.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAST-1:1], i_cell.valid};
        end
    end

    // Stages 1 to 8: one noise pipeline per octave and component. The octave shift
    // is a constant per instance, so the coordinate takes only adds and a wire shift.
    vnwf_pkg::t_noise noise [2][NO];

    for (genvar o = 0; o < NO; o++) begin : g_oct
        vnwf_pkg::t_coord bx, by;
        assign bx = {vnwf_pkg::CINT_W'(i_cell.cell_x) + vnwf_pkg::CINT_W'(4 * o), FB'(0)};
        assign by = {vnwf_pkg::CINT_W'(i_cell.cell_y) + vnwf_pkg::CINT_W'(4 * o), FB'(0)};

        vnwf_noise u_noise_x (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_inv (r_inv_scale),
            .i_qx  (bx >> o),
            .i_qy  (by >> o),
            .o_n   (noise[0][o])
        );

        vnwf_noise u_noise_y (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_inv (r_inv_scale),
            .i_qx  ((bx + vnwf_pkg::OFS_X_Q) >> o),
            .i_qy  ((by + vnwf_pkg::OFS_Y_Q) >> o),
            .o_n   (noise[1][o])
        );
    end

    // Stage 9 weights each octave, stages 10 to 12 add them in a tree, stage 13 applies
    // the gain and stage 14 rounds down and saturates into the output register.
    // The Q.16 sum stays far inside +-2^44, so no clamp is applied to it here.
    logic signed [SW-1:0]    r_w  [2][NO];
    logic signed [SW-1:0]    r_s1 [2][4];
    logic signed [SW-1:0]    r_s2 [2][2];
    logic signed [SW-1:0]    r_s3 [2];
    logic signed [GP_W-1:0]  r_g  [2];
    logic signed [vnwf_pkg::OUT_W-1:0] r_out [2];

    logic signed [WGT_W-1:0]  n_w [2][NO];
    logic signed [SH_W-1:0]   n_sh [2];
    logic signed [GP_W-FB-1:0] n_r [2];
    logic signed [vnwf_pkg::OUT_W-1:0] n_out [2];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            for (int o = 0; o < NO; o++) begin
                n_w[c][o] = WGT_W'(noise[c][o]) * WGT_W'($signed({1'b0, amp[o]}));
            end
            n_sh[c] = r_s3[c][SW-1:FB];
            n_r[c]  = r_g[c][GP_W-1:FB];
            if (n_r[c] > (GP_W-FB)'((1 << (vnwf_pkg::OUT_W-1)) - 1)) begin
                n_out[c] = vnwf_pkg::OUT_W'((1 << (vnwf_pkg::OUT_W-1)) - 1);
            end else if (n_r[c] < -(GP_W-FB)'(1 << (vnwf_pkg::OUT_W-1))) begin
                n_out[c] = vnwf_pkg::OUT_W'(-(1 << (vnwf_pkg::OUT_W-1)));
            end else begin
                n_out[c] = n_r[c][vnwf_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 2; c++) begin
                for (int o = 0; o < NO; o++) begin
                    r_w[c][o] <= oct_en[o] ? SW'(n_w[c][o]) : '0;
                end
                for (int k = 0; k < 4; k++) r_s1[c][k] <= r_w[c][2*k] + r_w[c][2*k+1];
                for (int k = 0; k < 2; k++) r_s2[c][k] <= r_s1[c][2*k] + r_s1[c][2*k+1];
                r_s3[c]  <= r_s2[c][0] + r_s2[c][1];
                r_g[c]   <= GP_W'(n_sh[c]) * GP_W'($signed({1'b0, r_norm_gain}));
                r_out[c] <= n_out[c];
            end
        end
    end

    assign o_wind.valid  = r_vld[LAST];
    assign o_wind.wind_x = r_out[0];
    assign o_wind.wind_y = r_out[1];

    // An accepted beat enters stage 1; an idle cycle leaves a bubble there.
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(adv) |-> r_vld[1] == $past(i_cell.valid))
        else $error("stage 1 valid does not follow the input handshake");

    // While the output is stalled, no valid bit moves.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(adv) |-> r_vld == $past(r_vld))
        else $error("pipeline moved during an output stall");

    // When the pipeline advances, every valid bit shifts by exactly one stage.
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(adv) |-> r_vld[LAST:2] == $past(r_vld[LAST-1:1]))
        else $error("valid bits lost or repeated in the pipeline");

endmodule

`default_nettype wire

>>> verif/value_noise_wind_field_tb.sv
// Self-checking testbench for value_noise_wind_field: directed cells, then random cells
// under several register settings. Depends on rtl/vnwf_pkg.sv, rtl/vnwf_if.sv and the RTL.
`timescale 1ns / 1ps

module value_noise_wind_field_tb;

    // Field widths taken from the package.
    localparam int CELL_W      = vnwf_pkg::CELL_W;
    localparam int OUT_W       = vnwf_pkg::OUT_W;
    localparam int CFG_DATA_W  = vnwf_pkg::CFG_DATA_W;
    localparam int INV_W       = vnwf_pkg::INV_W;
    localparam int OCT_W       = vnwf_pkg::OCT_W;
    localparam int PERS_W      = vnwf_pkg::PERS_W;
    localparam int GAIN_W      = vnwf_pkg::GAIN_W;
    localparam int MAX_OCTAVES = vnwf_pkg::MAX_OCTAVES;

    // Pipeline depth is 14; idle gaps before a register write and at the end use a margin.
    localparam int SETTLE_CYCLES = 24;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 100;

    // Constants of the noise, recomputed here rather than taken from the block.
    localparam longint unsigned Q_ONE  = 64'd1 << 16;
    localparam longint unsigned Q_MASK = Q_ONE - 1;
    localparam longint unsigned Q_PI   = ((64'd314159265 << 16) + 64'd50000000) / 64'd100000000;
    localparam longint unsigned Q_OFSX = ((64'd3141 << 16) + 64'd50) / 64'd100;
    localparam longint unsigned Q_OFSY = ((64'd2718 << 16) + 64'd50) / 64'd100;
    localparam longint          SUM_CAP = 64'sd1 << 44;

    typedef struct packed {
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
    } t_wind;

    typedef struct {
        bit                      cfg_en;
        vnwf_pkg::t_cfg_reg      idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [CELL_W-1:0]       x;
        logic [CELL_W-1:0]       y;
        bit                      known;
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    vnwf_cell_if cell_ch();
    vnwf_cfg_if  cfg_ch();
    vnwf_wind_if wind_ch();

    value_noise_wind_field DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cell  (cell_ch),
        .i_cfg   (cfg_ch),
        .o_wind  (wind_ch)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the registers as the block should hold them.
    logic [INV_W-1:0]  sh_inv;
    logic [OCT_W-1:0]  sh_oct;
    logic [PERS_W-1:0] sh_pers;
    logic [GAIN_W-1:0] sh_gain;

    t_wind pending_wind[$];
    int    fail_count = 0;
    int    idle_count = 0;
    bit    hold_req = 1'b0;
    int    burst_left = 0;

    // ---------------------------------------------------------------------------------------
    // Wind predictor. Every right shift is a floor, so signed values use arithmetic shifts.
    // ---------------------------------------------------------------------------------------
    function automatic longint unsigned hash_angle(input logic [31:0] ix, input logic [31:0] iy);
        logic [31:0] a;
        logic [31:0] b;
        a = ix * 32'd3284157443;
        b = iy ^ {a[15:0], a[31:16]};
        b = b * 32'd1911520717;
        a = a ^ {b[15:0], b[31:16]};
        a = a * 32'd2048419325;
        return ({32'd0, a} * Q_PI) >> 31;
    endfunction

    function automatic longint unsigned fade(input longint unsigned t);
        longint unsigned t2;
        t2 = (t * t) >> 16;
        return (t2 * (3 * Q_ONE - 2 * t)) >> 16;
    endfunction

    function automatic longint unsigned mix(input longint unsigned p, input longint unsigned q,
                                            input longint unsigned u);
        return (p * (Q_ONE - u) + q * u) >> 16;
    endfunction

    function automatic longint unsigned scaled(input longint unsigned c);
        return (((c >> 16) * sh_inv) << 16) + (((c & Q_MASK) * sh_inv) >> 16);
    endfunction

    function automatic longint lattice_value(input longint unsigned qx, input longint unsigned qy);
        logic [31:0]     ix;
        logic [31:0]     iy;
        longint unsigned u;
        longint unsigned v;
        longint unsigned top;
        longint unsigned bot;
        ix  = qx[47:16];
        iy  = qy[47:16];
        u   = fade(qx & Q_MASK);
        v   = fade(qy & Q_MASK);
        top = mix(hash_angle(ix, iy), hash_angle(ix + 32'd1, iy), u);
        bot = mix(hash_angle(ix, iy + 32'd1), hash_angle(ix + 32'd1, iy + 32'd1), u);
        return longint'(2 * mix(top, bot, v)) - longint'(Q_ONE);
    endfunction

    function automatic logic signed [OUT_W-1:0] gain_out(input longint acc);
        longint s;
        longint r;
        s = acc >>> 16;
        if (s > SUM_CAP) s = SUM_CAP;
        if (s < -SUM_CAP) s = -SUM_CAP;
        r = (s * longint'({47'd0, sh_gain})) >>> 16;
        if (r > 1048575) r = 1048575;
        if (r < -1048576) r = -1048576;
        return r[OUT_W-1:0];
    endfunction

    function automatic t_wind predict_wind(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y);
        longint unsigned n;
        longint unsigned amp;
        longint unsigned bx;
        longint unsigned by;
        longint          sx;
        longint          sy;
        t_wind           w;
        n   = (sh_oct > MAX_OCTAVES) ? MAX_OCTAVES : sh_oct;
        amp = Q_ONE;
        sx  = 0;
        sy  = 0;
        for (longint unsigned o = 0; o < n; o++) begin
            bx = (longint'(x) + 4 * o) << 16;
            by = (longint'(y) + 4 * o) << 16;
            sx += lattice_value(scaled(bx >> o), scaled(by >> o)) * longint'(amp);
            sy += lattice_value(scaled((bx + Q_OFSX) >> o), scaled((by + Q_OFSY) >> o))
                  * longint'(amp);
            amp = (amp * sh_pers) >> 16;
            if (amp > (64'd1 << 30)) amp = 64'd1 << 30;
        end
        w.wx = gain_out(sx);
        w.wy = gain_out(sy);
        return w;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Drivers. Each task returns at the edge where its beat was accepted, or after the gap send_cell may add.
    // ---------------------------------------------------------------------------------------
    task automatic write_reg(input vnwf_pkg::t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            vnwf_pkg::REG_INV_SCALE:   sh_inv  = data[INV_W-1:0];
            vnwf_pkg::REG_OCTAVES:     sh_oct  = data[OCT_W-1:0];
            vnwf_pkg::REG_PERSISTENCE: sh_pers = data[PERS_W-1:0];
            vnwf_pkg::REG_NORM_GAIN:   sh_gain = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every expected wind beat is out, then lets the pipeline empty.
    task automatic drain();
        while (pending_wind.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offers one cell. The prediction is queued only once the beat is accepted, and the
    // sender then may take a gap, which ends the current burst.
    task automatic send_cell(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                             input bit known, input t_wind known_wind);
        int gap;
        cell_ch.valid  <= 1'b1;
        cell_ch.cell_x <= x;
        cell_ch.cell_y <= y;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
        pending_wind.push_back(known ? known_wind : predict_wind(x, y));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                cell_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function automatic logic [CELL_W-1:0] pick_cell();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return CELL_W'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------------------------------
    // Receiver: free-running stretches, random stalls and a periodic pattern, plus one long
    // hold-off on request so that the pipeline fills and the cell input backs up.
    // ---------------------------------------------------------------------------------------
    initial begin
        int mode;
        int span;
        wind_ch.ready = 1'b0;
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYCLES) begin
                    wind_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(5, 60);
            for (int k = 0; k < span; k++) begin
                case (mode)
                    0:       wind_ch.ready <= 1'b1;
                    1:       wind_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: wind_ch.ready <= (k % 3 != 2);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Checks every accepted wind beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_wind exp_w;
        if (i_rst_n && wind_ch.valid && wind_ch.ready) begin
            if (pending_wind.size() == 0) begin
                $error("wind beat with no cell pending: wind_x=%0d wind_y=%0d",
                       wind_ch.wind_x, wind_ch.wind_y);
                fail_count++;
            end else begin
                exp_w = pending_wind.pop_front();
                if (wind_ch.wind_x !== exp_w.wx) begin
                    $error("wind_x expected %0d actual %0d", exp_w.wx, wind_ch.wind_x);
                    fail_count++;
                end
                if (wind_ch.wind_y !== exp_w.wy) begin
                    $error("wind_y expected %0d actual %0d", exp_w.wy, wind_ch.wind_y);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no beat on any channel ends the run.
    always @(posedge i_clk) begin
        if ((cell_ch.valid && cell_ch.ready) || (wind_ch.valid && wind_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
            if (idle_count >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Directed cells. A row may first write one register; the wind is typed in only where it
    // is plainly zero (no octaves or zero gain), otherwise the predictor supplies it.
    // ---------------------------------------------------------------------------------------
    t_dir_row dir_rows [17] = '{
        '{0, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd0,    10'd0,    0, 21'sd0, 21'sd0},
        '{0, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd1023, 10'd1023, 0, 21'sd0, 21'sd0},
        '{0, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd0,    10'd1023, 0, 21'sd0, 21'sd0},
        '{0, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd1023, 10'd0,    0, 21'sd0, 21'sd0},
        // Zero scale: every lattice coordinate collapses to the origin.
        '{1, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd517,  10'd200,  0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_INV_SCALE,   24'hFFFFFF, 10'd1023, 10'd1023, 0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_INV_SCALE,   24'd1,      10'd1,    10'd2,    0, 21'sd0, 21'sd0},
        // An octave count above the maximum is clipped to eight.
        '{1, vnwf_pkg::REG_OCTAVES,     24'd15,     10'd3,    10'd700,  0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_OCTAVES,     24'd1,      10'd1000, 10'd5,    0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_OCTAVES,     24'd8,      10'd100,  10'd100,  0, 21'sd0, 21'sd0},
        // Largest persistence drives the amplitude close to its ceiling.
        '{1, vnwf_pkg::REG_PERSISTENCE, 24'h3FFFF,  10'd1023, 10'd0,    0, 21'sd0, 21'sd0},
        // Largest gain pushes the outputs into saturation.
        '{1, vnwf_pkg::REG_NORM_GAIN,   24'h1FFFF,  10'd600,  10'd600,  0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_PERSISTENCE, 24'd0,      10'd45,   10'd900,  0, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_NORM_GAIN,   24'd0,      10'd12,   10'd34,   1, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_OCTAVES,     24'd0,      10'd0,    10'd0,    1, 21'sd0, 21'sd0},
        '{1, vnwf_pkg::REG_NORM_GAIN,   24'd65536,  10'd1023, 10'd1023, 1, 21'sd0, 21'sd0},
        '{0, vnwf_pkg::REG_INV_SCALE,   24'd0,      10'd511,  10'd512,  1, 21'sd0, 21'sd0}
    };

    initial begin
        t_wind typed;
        cell_ch.valid  = 1'b0;
        cell_ch.cell_x = '0;
        cell_ch.cell_y = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = vnwf_pkg::REG_INV_SCALE;
        cfg_ch.data    = '0;
        sh_inv  = vnwf_pkg::RST_INV_SCALE;
        sh_oct  = vnwf_pkg::RST_OCTAVES;
        sh_pers = vnwf_pkg::RST_PERSISTENCE;
        sh_gain = vnwf_pkg::RST_NORM_GAIN;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_en) begin
                cell_ch.valid <= 1'b0;
                drain();
                write_reg(dir_rows[r].idx, dir_rows[r].data);
            end
            typed.wx = dir_rows[r].wx;
            typed.wy = dir_rows[r].wy;
            send_cell(dir_rows[r].x, dir_rows[r].y, dir_rows[r].known, typed);
        end

        // Random phases, each under a fresh setting of all four registers. The first one
        // returns to the reset values; extremes come up often in the others.
        for (int p = 0; p < PHASES; p++) begin
            cell_ch.valid <= 1'b0;
            drain();
            if (p == 0) begin
                write_reg(vnwf_pkg::REG_INV_SCALE, CFG_DATA_W'(vnwf_pkg::RST_INV_SCALE));
                write_reg(vnwf_pkg::REG_OCTAVES, CFG_DATA_W'(vnwf_pkg::RST_OCTAVES));
                write_reg(vnwf_pkg::REG_PERSISTENCE, CFG_DATA_W'(vnwf_pkg::RST_PERSISTENCE));
                write_reg(vnwf_pkg::REG_NORM_GAIN, CFG_DATA_W'(vnwf_pkg::RST_NORM_GAIN));
            end else begin
                case ($urandom_range(0, 3))
                    0:       write_reg(vnwf_pkg::REG_INV_SCALE, 24'hFFFFFF);
                    1:       write_reg(vnwf_pkg::REG_INV_SCALE, 24'd1);
                    default: write_reg(vnwf_pkg::REG_INV_SCALE, 24'($urandom));
                endcase
                write_reg(vnwf_pkg::REG_OCTAVES, ($urandom_range(0, 4) == 0)
                          ? 24'($urandom_range(0, 15)) : 24'($urandom_range(1, 8)));
                case ($urandom_range(0, 3))
                    0:       write_reg(vnwf_pkg::REG_PERSISTENCE, 24'd131072);
                    1:       write_reg(vnwf_pkg::REG_PERSISTENCE, 24'h3FFFF);
                    default: write_reg(vnwf_pkg::REG_PERSISTENCE,
                                       24'($urandom_range(0, 131072)));
                endcase
                case ($urandom_range(0, 4))
                    0:       write_reg(vnwf_pkg::REG_NORM_GAIN, 24'd65536);
                    1:       write_reg(vnwf_pkg::REG_NORM_GAIN, 24'h1FFFF);
                    default: write_reg(vnwf_pkg::REG_NORM_GAIN, 24'($urandom_range(1, 65536)));
                endcase
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // Mid-run the receiver holds off for a long stretch while cells keep coming.
                if (p == 3 && k == 10) hold_req = 1'b1;
                send_cell(pick_cell(), pick_cell(), 1'b0, typed);
            end
        end

        cell_ch.valid <= 1'b0;
        drain();
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
